[rtl/rbnh_pkg.sv]
// Shared types and constants for the ray/box nearest-hit picker.
`timescale 1ns / 1ps
`default_nettype none
package rbnh_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DIR_WIDTH   = 18;
    localparam int ADDR_WIDTH  = 5;

    // Register byte addresses
    localparam logic [ADDR_WIDTH-1:0] ADDR_ORIGIN_X = 5'd0;
    localparam logic [ADDR_WIDTH-1:0] ADDR_ORIGIN_Y = 5'd4;
    localparam logic [ADDR_WIDTH-1:0] ADDR_ORIGIN_Z = 5'd8;
    localparam logic [ADDR_WIDTH-1:0] ADDR_DIR_X    = 5'd12;
    localparam logic [ADDR_WIDTH-1:0] ADDR_DIR_Y    = 5'd16;
    localparam logic [ADDR_WIDTH-1:0] ADDR_DIR_Z    = 5'd20;

    localparam logic signed [COORD_WIDTH-1:0] T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] T_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] box_min_x;
        logic signed [COORD_WIDTH-1:0] box_min_y;
        logic signed [COORD_WIDTH-1:0] box_min_z;
        logic signed [COORD_WIDTH-1:0] box_max_x;
        logic signed [COORD_WIDTH-1:0] box_max_y;
        logic signed [COORD_WIDTH-1:0] box_max_z;
        logic [31:0]                   object_id;
        logic                          solid;
        logic                          last_box;
    } box_in_t;

    typedef struct packed {
        logic                          box_hit;
        logic signed [COORD_WIDTH-1:0] box_distance;
        logic                          nearest_found;
        logic [31:0]                   nearest_id;
        logic signed [COORD_WIDTH-1:0] nearest_distance;
        logic                          pick_done;
    } hit_out_t;

    // Classified slab job handed from front to back
    typedef struct packed {
        logic [2:0]                     moving;     // axis has nonzero direction
        logic                           par_miss;   // a parallel axis rejects the box
        logic signed [COORD_WIDTH:0]    dmin_x;
        logic signed [COORD_WIDTH:0]    dmin_y;
        logic signed [COORD_WIDTH:0]    dmin_z;
        logic signed [COORD_WIDTH:0]    dmax_x;
        logic signed [COORD_WIDTH:0]    dmax_y;
        logic signed [COORD_WIDTH:0]    dmax_z;
        logic [31:0]                    object_id;
        logic                           solid;
        logic                           last_box;
    } slab_job_t;

endpackage
`default_nettype wire

[rtl/rbnh_front.sv]
// Front end: accepts boxes, forms offsets to the origin and checks parallel axes.
`timescale 1ns / 1ps
`default_nettype none
module rbnh_front (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire rbnh_pkg::box_in_t                       box,
    input  wire logic                                    push,
    output logic                                         full,
    input  wire logic signed [rbnh_pkg::COORD_WIDTH-1:0] origin_x,
    input  wire logic signed [rbnh_pkg::COORD_WIDTH-1:0] origin_y,
    input  wire logic signed [rbnh_pkg::COORD_WIDTH-1:0] origin_z,
    input  wire logic signed [rbnh_pkg::DIR_WIDTH-1:0]   dir_x,
    input  wire logic signed [rbnh_pkg::DIR_WIDTH-1:0]   dir_y,
    input  wire logic signed [rbnh_pkg::DIR_WIDTH-1:0]   dir_z,
    output rbnh_pkg::slab_job_t                          job,
    output logic                                         job_valid,
    input  wire logic                                    job_take
);
    // Two-entry queue towards the back end
    rbnh_pkg::slab_job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;
    rbnh_pkg::slab_job_t cls;
    logic acc, tk;

    localparam int CW = rbnh_pkg::COORD_WIDTH;

    function automatic logic signed [CW:0] sdiff(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        sdiff = {a[CW-1], a} - {b[CW-1], b};
    endfunction

    always_comb
    begin
        cls.moving    = {dir_z != '0, dir_y != '0, dir_x != '0};
        cls.par_miss  = ((dir_x == '0) && (origin_x < box.box_min_x || origin_x > box.box_max_x))
                     || ((dir_y == '0) && (origin_y < box.box_min_y || origin_y > box.box_max_y))
                     || ((dir_z == '0) && (origin_z < box.box_min_z || origin_z > box.box_max_z));
        cls.dmin_x    = sdiff(box.box_min_x, origin_x);
        cls.dmin_y    = sdiff(box.box_min_y, origin_y);
        cls.dmin_z    = sdiff(box.box_min_z, origin_z);
        cls.dmax_x    = sdiff(box.box_max_x, origin_x);
        cls.dmax_y    = sdiff(box.box_max_y, origin_y);
        cls.dmax_z    = sdiff(box.box_max_z, origin_z);
        cls.object_id = box.object_id;
        cls.solid     = box.solid;
        cls.last_box  = box.last_box;
    end

    assign full      = (cnt_reg == 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_reg];
    assign acc       = push && !full;
    assign tk        = job_take && job_valid;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                wr_reg <= ~wr_reg;
            end
            if (tk)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, acc} - {1'b0, tk};
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !(cnt_reg == 2'd2 && acc)) else $error("queue overrun");
    a_cnt_rng: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (rd_reg == wr_reg))
        else $error("queue pointers disagree with count");
`endif
endmodule
`default_nettype wire

[rtl/rbnh_divider.sv]
// Restoring divider: signed 49-bit numerator by 18-bit divisor, saturated to 32 bits.
`timescale 1ns / 1ps
`default_nettype none
module rbnh_divider (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    input  wire logic signed [rbnh_pkg::COORD_WIDTH:0]   diff,
    input  wire logic signed [rbnh_pkg::DIR_WIDTH-1:0]   dir,
    output logic                                         done,
    output logic signed [rbnh_pkg::COORD_WIDTH-1:0]      quot
);
    localparam int CW = rbnh_pkg::COORD_WIDTH;
    localparam int NW = CW + 1 + rbnh_pkg::FRAC_BITS;  // numerator magnitude bits
    localparam int DW = rbnh_pkg::DIR_WIDTH;
    localparam int SPC = 4;                            // quotient bits per cycle
    localparam int STEPS = (NW + SPC - 1) / SPC;
    localparam int QW = STEPS * SPC;
    localparam int SW = $clog2(STEPS + 1);

    logic [QW-1:0] num_reg;   // numerator shifts out, quotient shifts in
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic          neg_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;

    logic [DW:0]   r;
    logic [QW-1:0] n;
    logic [NW-1:0] mag;
    logic [DW-1:0] dmag;
    logic signed [NW-1:0] snum;

    always_comb
    begin
        r = rem_reg;
        n = num_reg;
        for (int i = 0; i < SPC; i++)
        begin
            r = {r[DW-1:0], n[QW-1]};
            n = {n[QW-2:0], 1'b0};
            if (r >= {1'b0, den_reg})
            begin
                r    = r - {1'b0, den_reg};
                n[0] = 1'b1;
            end
        end
        snum = {diff, {rbnh_pkg::FRAC_BITS{1'b0}}};
        mag  = snum[NW-1] ? NW'(-snum) : NW'(snum);
        dmag = dir[DW-1] ? DW'(-dir) : dir;
    end

    // Saturate the signed quotient
    always_comb
    begin
        if (num_reg[QW-1:CW-1] != '0)
        begin
            quot = neg_reg ? rbnh_pkg::T_MIN : rbnh_pkg::T_MAX;
        end
        else
        begin
            quot = neg_reg ? CW'(-$signed({1'b0, num_reg[CW-1:0]}))
                           : $signed(num_reg[CW-1:0]);
        end
    end

    assign done = busy_reg && (step_reg == SW'(STEPS));

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= QW'(mag);
            rem_reg <= '0;
            den_reg <= dmag;
            neg_reg <= diff[CW] ^ dir[DW-1];
        end
        else if (busy_reg && !done)
        begin
            num_reg <= n;
            rem_reg <= r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end
endmodule
`default_nettype wire

[rtl/rbnh_back.sv]
// Back end: runs the six slab divisions, intersects the slabs and tracks the nearest hit.
`timescale 1ns / 1ps
`default_nettype none
module rbnh_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire rbnh_pkg::slab_job_t                   job,
    input  wire logic                                  job_valid,
    output logic                                       job_take,
    input  wire logic signed [rbnh_pkg::DIR_WIDTH-1:0] dir_x,
    input  wire logic signed [rbnh_pkg::DIR_WIDTH-1:0] dir_y,
    input  wire logic signed [rbnh_pkg::DIR_WIDTH-1:0] dir_z,
    output rbnh_pkg::hit_out_t                         result,
    output logic                                       empty,
    input  wire logic                                  pop
);
    localparam int CW = rbnh_pkg::COORD_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] slot_reg;     // 0..5: min x,y,z then max x,y,z
    logic       div_start_reg;
    rbnh_pkg::slab_job_t jb_reg;
    logic signed [CW-1:0] t_reg [6];

    logic signed [CW:0]                 dv;
    logic signed [rbnh_pkg::DIR_WIDTH-1:0] dd;
    logic                               dn;
    logic signed [CW-1:0]               q;

    logic signed [CW-1:0] best_dist_reg;
    logic [31:0]          best_obj_reg;
    logic                 any_reg;
    rbnh_pkg::hit_out_t   out_reg;
    logic                 full_reg;

    logic signed [CW-1:0] tmn, tmx, lo, hi;
    logic                 hit, miss;
    logic signed [CW-1:0] hit_dist;
    logic                 upd;

    always_comb
    begin
        case (slot_reg)
            3'd0:    begin dv = jb_reg.dmin_x; dd = dir_x; end
            3'd1:    begin dv = jb_reg.dmin_y; dd = dir_y; end
            3'd2:    begin dv = jb_reg.dmin_z; dd = dir_z; end
            3'd3:    begin dv = jb_reg.dmax_x; dd = dir_x; end
            3'd4:    begin dv = jb_reg.dmax_y; dd = dir_y; end
            default: begin dv = jb_reg.dmax_z; dd = dir_z; end
        endcase
    end

    rbnh_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .diff  (dv),
        .dir   (dd),
        .done  (dn),
        .quot  (q)
    );

    // Intersect the slabs; a parallel axis was already settled up front
    always_comb
    begin
        tmn  = rbnh_pkg::T_MIN;
        tmx  = rbnh_pkg::T_MAX;
        miss = jb_reg.par_miss;
        for (int a = 0; a < 3; a++)
        begin
            lo = (t_reg[a] > t_reg[a+3]) ? t_reg[a+3] : t_reg[a];
            hi = (t_reg[a] > t_reg[a+3]) ? t_reg[a]   : t_reg[a+3];
            if (jb_reg.moving[a])
            begin
                if (lo > tmn) tmn = lo;
                if (hi < tmx) tmx = hi;
                if (tmn > tmx) miss = 1'b1;
            end
        end
        hit      = jb_reg.solid && !miss && !tmx[CW-1];
        hit_dist = hit ? (tmn[CW-1] ? tmx : tmn) : '0;
        upd      = hit && (hit_dist < best_dist_reg);
    end

    // Slot needs a division only when its axis moves
    function automatic logic mv(input logic [2:0] m, input logic [2:0] s);
        case (s)
            3'd0, 3'd3: mv = m[0];
            3'd1, 3'd4: mv = m[1];
            default:    mv = m[2];
        endcase
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (job_valid) state_next = S_DIV;
            S_DIV:   state_next = S_WAIT;
            S_WAIT:  if (dn || !mv(jb_reg.moving, slot_reg))
                         state_next = (slot_reg == 3'd5) ? S_FIN : S_DIV;
            S_FIN:   if (!full_reg || pop) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign job_take = (state_reg == S_IDLE) && job_valid;
    assign empty    = !full_reg;
    assign result   = out_reg;

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            jb_reg <= job;
        end
        if (state_reg == S_WAIT && dn)
        begin
            t_reg[slot_reg] <= q;
        end
        if (state_reg == S_FIN && (!full_reg || pop))
        begin
            out_reg.box_hit          <= hit;
            out_reg.box_distance     <= hit_dist;
            out_reg.nearest_found    <= any_reg || upd;
            out_reg.nearest_id       <= upd ? jb_reg.object_id : (any_reg ? best_obj_reg : '0);
            out_reg.nearest_distance <= upd ? hit_dist : (any_reg ? best_dist_reg : '0);
            out_reg.pick_done        <= jb_reg.last_box;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            div_start_reg <= 1'b0;
            full_reg      <= 1'b0;
            best_dist_reg <= rbnh_pkg::T_MAX;
            best_obj_reg  <= '0;
            any_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= (state_reg != S_DIV && state_next == S_DIV)
                          || (state_reg == S_WAIT && state_next == S_DIV);
            if (state_reg == S_IDLE)
            begin
                slot_reg <= '0;
            end
            else if (state_reg == S_WAIT && state_next == S_DIV)
            begin
                slot_reg <= slot_reg + 3'd1;
            end
            if (state_reg == S_FIN && (!full_reg || pop))
            begin
                full_reg <= 1'b1;
                if (jb_reg.last_box)
                begin
                    best_dist_reg <= rbnh_pkg::T_MAX;
                    best_obj_reg  <= '0;
                    any_reg       <= 1'b0;
                end
                else if (upd)
                begin
                    best_dist_reg <= hit_dist;
                    best_obj_reg  <= jb_reg.object_id;
                    any_reg       <= 1'b1;
                end
            end
            else if (pop && full_reg)
            begin
                full_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> (state_reg == S_DIV)) else $error("job taken but no division started");
    a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> div_start_reg)
        else $error("division slot without start");
    a_no_hit_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !jb_reg.solid) |-> !hit) else $error("skipped box hit");
    a_any_best: assert property (@(posedge clk) disable iff (!rst_n)
        !any_reg |-> (best_dist_reg == rbnh_pkg::T_MAX)) else $error("best kept without hit");
`endif
endmodule
`default_nettype wire

[rtl/ray_box_nearest_hit_picker.sv]
// Top level of the ray/box nearest-hit picker: config registers, front and back ends.
//  channel | handshake          | payload
//  boxes   | push / full        | box (rbnh_pkg::box_in_t)
//  results | pop / empty        | result (rbnh_pkg::hit_out_t)
//  config  | psel/penable/pwrite| paddr, pwdata, prdata, pready
// Each box passes a take state, six slab divisions (each a start state, then a wait for
// 13 quotient steps of four bits through the single shared divider) and a finish state.
// A parallel axis does not wait for its two divisions.
// A two-item queue holds classified boxes, so input is taken while the back end divides.
// The finished result waits in an output register; the next box's divisions go on meanwhile.
// Reset is asynchronous active-low; it clears the queue and the pick, and resets the ray to the origin along +z.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_nearest_hit_picker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire rbnh_pkg::box_in_t                   box,
    input  wire logic                                push,
    output logic                                     full,
    output rbnh_pkg::hit_out_t                       result,
    output logic                                     empty,
    input  wire logic                                pop,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rbnh_pkg::ADDR_WIDTH-1:0]     paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    logic signed [rbnh_pkg::COORD_WIDTH-1:0] org_x_reg, org_y_reg, org_z_reg;
    logic signed [rbnh_pkg::DIR_WIDTH-1:0]   dir_x_reg, dir_y_reg, dir_z_reg;
    rbnh_pkg::slab_job_t job;
    logic job_valid, job_take;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // Write the ray registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= rbnh_pkg::DIR_WIDTH'(65536);
        end
        else if (wr)
        begin
            case (paddr)
                rbnh_pkg::ADDR_ORIGIN_X: org_x_reg <= pwdata;
                rbnh_pkg::ADDR_ORIGIN_Y: org_y_reg <= pwdata;
                rbnh_pkg::ADDR_ORIGIN_Z: org_z_reg <= pwdata;
                rbnh_pkg::ADDR_DIR_X:    dir_x_reg <= pwdata[rbnh_pkg::DIR_WIDTH-1:0];
                rbnh_pkg::ADDR_DIR_Y:    dir_y_reg <= pwdata[rbnh_pkg::DIR_WIDTH-1:0];
                rbnh_pkg::ADDR_DIR_Z:    dir_z_reg <= pwdata[rbnh_pkg::DIR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Read back, direction sign-extended
    always_comb
    begin
        case (paddr)
            rbnh_pkg::ADDR_ORIGIN_X: prdata = org_x_reg;
            rbnh_pkg::ADDR_ORIGIN_Y: prdata = org_y_reg;
            rbnh_pkg::ADDR_ORIGIN_Z: prdata = org_z_reg;
            rbnh_pkg::ADDR_DIR_X:    prdata = 32'(dir_x_reg);
            rbnh_pkg::ADDR_DIR_Y:    prdata = 32'(dir_y_reg);
            rbnh_pkg::ADDR_DIR_Z:    prdata = 32'(dir_z_reg);
            default:                 prdata = '0;
        endcase
    end

    rbnh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .box       (box),
        .push      (push),
        .full      (full),
        .origin_x  (org_x_reg),
        .origin_y  (org_y_reg),
        .origin_z  (org_z_reg),
        .dir_x     (dir_x_reg),
        .dir_y     (dir_y_reg),
        .dir_z     (dir_z_reg),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take)
    );

    rbnh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_take  (job_take),
        .dir_x     (dir_x_reg),
        .dir_y     (dir_y_reg),
        .dir_z     (dir_z_reg),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

`ifndef SYNTHESIS
    a_ready: assert property (@(posedge clk) pready) else $error("pready dropped");
    a_dirz_rst: assert property (@(posedge clk) $rose(rst_n) |-> dir_z_reg == 18'sd65536)
        else $error("dir_z reset value lost");
    a_wr_x: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && paddr == rbnh_pkg::ADDR_ORIGIN_X) |=> org_x_reg == $past(pwdata))
        else $error("origin_x write lost");
`endif
endmodule
`default_nettype wire

[test/tb_ray_box_nearest_hit_picker.sv]
// Testbench for the ray/box nearest-hit picker: directed and random boxes against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_ray_box_nearest_hit_picker;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    // Block ports
    rbnh_pkg::box_in_t       box = '0;
    logic                    push = 1'b0;
    logic                    full;
    rbnh_pkg::hit_out_t      result;
    logic                    empty;
    logic                    pop = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [rbnh_pkg::ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    ray_box_nearest_hit_picker u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .box     (box),
        .push    (push),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Ray held by the predictor, mirrored from every register write
    logic signed [31:0]        ray_org [3];
    logic signed [rbnh_pkg::DIR_WIDTH-1:0] ray_dir [3];

    // Nearest-hit tracking of the current pick
    logic signed [31:0] near_dist;
    logic [31:0]        near_id;
    logic               near_any;

    rbnh_pkg::hit_out_t expected_hits [$];
    int       mismatches = 0;
    bit       stall_enable = 1'b1;

    // Saturate a wide signed quotient to the 32-bit distance range
    function automatic logic signed [31:0] clamp_t(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Slab distance: (bound - origin) * 2^16 / dir, truncated toward zero
    function automatic logic signed [31:0] slab_t(input logic signed [31:0] bound,
                                                  input logic signed [31:0] org,
                                                  input logic signed [rbnh_pkg::DIR_WIDTH-1:0] dir);
        logic signed [63:0] num;
        logic signed [63:0] den;
        num = (64'(bound) - 64'(org)) * 64'sd65536;
        den = 64'(dir);
        return clamp_t(num / den);
    endfunction

    // Run the slab test and tracking for one box, return the expected result
    function automatic rbnh_pkg::hit_out_t predict_hit(input rbnh_pkg::box_in_t b);
        rbnh_pkg::hit_out_t r;
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] tmin, tmax, t1, t2, tt;
        logic hit;
        logic signed [31:0] hit_dist;
        lo = '{b.box_min_x, b.box_min_y, b.box_min_z};
        hi = '{b.box_max_x, b.box_max_y, b.box_max_z};
        hit = 1'b0;
        hit_dist = '0;
        if (b.solid)
        begin
            tmin = rbnh_pkg::T_MIN;
            tmax = rbnh_pkg::T_MAX;
            hit = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                if (!hit)
                    continue;
                if (ray_dir[a] == 0)
                begin
                    if (ray_org[a] < lo[a] || ray_org[a] > hi[a])
                        hit = 1'b0;
                end
                else
                begin
                    t1 = slab_t(lo[a], ray_org[a], ray_dir[a]);
                    t2 = slab_t(hi[a], ray_org[a], ray_dir[a]);
                    if (t1 > t2)
                    begin
                        tt = t1;
                        t1 = t2;
                        t2 = tt;
                    end
                    if (t1 > tmin)
                        tmin = t1;
                    if (t2 < tmax)
                        tmax = t2;
                    if (tmin > tmax)
                        hit = 1'b0;
                end
            end
            if (hit && tmax < 0)
                hit = 1'b0;
            if (hit)
                hit_dist = (tmin >= 0) ? tmin : tmax;
            if (hit && hit_dist < near_dist)
            begin
                near_dist = hit_dist;
                near_id = b.object_id;
                near_any = 1'b1;
            end
        end
        r.box_hit = hit;
        r.box_distance = hit_dist;
        r.nearest_found = near_any;
        r.nearest_id = near_any ? near_id : '0;
        r.nearest_distance = near_any ? near_dist : '0;
        r.pick_done = b.last_box;
        if (b.last_box)
        begin
            near_dist = rbnh_pkg::T_MAX;
            near_id = '0;
            near_any = 1'b0;
        end
        return r;
    endfunction

    // Send one box: hold push until the block takes it, then drop it for a cycle
    task automatic send_box(input rbnh_pkg::box_in_t b);
        box <= b;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        expected_hits.push_back(predict_hit(b));
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Write one ray register through the setup and access phases
    task automatic write_reg(input int idx, input logic [31:0] value);
        logic [rbnh_pkg::ADDR_WIDTH-1:0] addr;
        case (idx)
            0: addr = rbnh_pkg::ADDR_ORIGIN_X;
            1: addr = rbnh_pkg::ADDR_ORIGIN_Y;
            2: addr = rbnh_pkg::ADDR_ORIGIN_Z;
            3: addr = rbnh_pkg::ADDR_DIR_X;
            4: addr = rbnh_pkg::ADDR_DIR_Y;
            default: addr = rbnh_pkg::ADDR_DIR_Z;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx < 3)
            ray_org[idx] = value;
        else
            ray_dir[idx-3] = value[rbnh_pkg::DIR_WIDTH-1:0];
        @(posedge clk);
    endtask

    // Wait until every expected result is back, plus the back end's latency
    task automatic drain_results();
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_ray(input logic [31:0] ox, oy, oz, input logic [31:0] dx, dy, dz);
        drain_results();
        write_reg(0, ox);
        write_reg(1, oy);
        write_reg(2, oz);
        write_reg(3, dx);
        write_reg(4, dy);
        write_reg(5, dz);
    endtask

    function automatic rbnh_pkg::box_in_t make_box(input int lx, ly, lz, hx, hy, hz,
                                                   input logic [31:0] id, input logic s, l);
        rbnh_pkg::box_in_t b;
        b.box_min_x = lx; b.box_min_y = ly; b.box_min_z = lz;
        b.box_max_x = hx; b.box_max_y = hy; b.box_max_z = hz;
        b.object_id = id;
        b.solid = s;
        b.last_box = l;
        return b;
    endfunction

    // Small coordinates keep hits likely; now and then a full-range value
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom_range(0, 1) ? 32'd65536 : -32'sd65536;
            2: return {{14{1'b0}}, 18'($urandom())};
            default: return $signed($urandom_range(0, 131072)) - 65536;
        endcase
    endfunction

    // Directed: ray along +z, front, behind, inside, parallel misses, skips, ties
    task automatic test_directed();
        set_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000);
        send_box(make_box(-65536, -65536, 5 << 16, 65536, 65536, 6 << 16, 32'h11, 1, 0));
        send_box(make_box(-65536, -65536, 3 << 16, 65536, 65536, 4 << 16, 32'h22, 1, 0));
        send_box(make_box(-65536, -65536, 3 << 16, 65536, 65536, 9 << 16, 32'h33, 1, 0));
        send_box(make_box(-65536, -65536, -9 << 16, 65536, 65536, -2 << 16, 32'h44, 1, 0));
        send_box(make_box(-65536, -65536, -1 << 16, 65536, 65536, 2 << 16, 32'h55, 1, 0));
        send_box(make_box(2 << 16, -65536, 1, 3 << 16, 65536, 2, 32'h66, 1, 0));
        send_box(make_box(65536, -65536, 1, -65536, 65536, 2, 32'h77, 1, 0));
        send_box(make_box(-65536, -65536, 0, 65536, 65536, 1, 32'hffffffff, 0, 0));
        send_box(make_box(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h88, 1, 1));
        send_box(make_box(-65536, -65536, 3 << 16, 65536, 65536, 4 << 16, 32'h99, 0, 1));
        set_ray(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h1, 32'h3ffff, 32'h20000);
        send_box(make_box(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'haa, 1, 0));
        send_box(make_box(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hbb, 1, 1));
        set_ray(32'h7fffffff, 32'h80000000, 32'h0, 32'h20000, 32'h10000, 32'h3ffff);
        send_box(make_box(32'h80000000, 32'h80000000, -65536,
                          32'h7fffffff, 32'h7fffffff, 65536, 32'hcc, 1, 1));
    endtask

    // Random: mostly well-formed picks, bursts with gaps, occasional new rays
    task automatic test_random(input int n_items);
        int sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 49) == 0)
                set_ray(rand_coord(), rand_coord(), rand_coord(),
                        rand_dir(), rand_dir(), rand_dir());
            for (int k = $urandom_range(1, 8); k > 0 && sent < n_items; k--)
            begin
                send_box(make_box(rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), rand_coord(), $urandom(),
                                  $urandom_range(0, 7) != 0, $urandom_range(0, 5) == 0));
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    // Hold back the next box until every result has come home, then send random boxes with the receiver never stalling
    task automatic test_pause_until_drained();
        for (int k = 0; k < 6; k++)
            send_box(make_box(rand_coord(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord(), $urandom(),
                              1'b1, k == 5));
        while (expected_hits.size() != 0)
            @(posedge clk);
        stall_enable = 1'b0;
        test_random(60);
        stall_enable = 1'b1;
    endtask

    // Receiver: stall in runs of its own, compare each taken item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                rbnh_pkg::hit_out_t want;
                want = expected_hits.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, result);
                end
            end
        end
        pop <= !stall_enable || ($urandom_range(0, 99) < (($time / 4000) % 2 ? 85 : 40));
    end

    initial
    begin
        ray_org = '{default: '0};
        ray_dir = '{0, 0, 18'sd65536};
        near_dist = rbnh_pkg::T_MAX;
        near_id = '0;
        near_any = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pause_until_drained();
        test_random(1300);
        drain_results();
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("tb_ray_box_nearest_hit_picker: done, clean");
        else
            $display("tb_ray_box_nearest_hit_picker: done, errors");
        $finish;
    end

    // Watchdog: room for every box, stalls and register phases, many times over
    initial
    begin
        #3000000;
        $display("tb_ray_box_nearest_hit_picker: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
